// ----- design/multichannel_moving_average_unit_assert.svh -----
// Assertion macros used by the checker file mma_checker.sv.
`ifndef MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define MMA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("multichannel moving average: check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define MMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("multichannel moving average: check failed");

`endif

// ----- design/mma_pkg.sv -----
package mma_pkg;

  localparam int NUM_CHANNELS = 10;
  localparam int MAX_WINDOW   = 12;
  localparam int HIST_DEPTH   = NUM_CHANNELS * MAX_WINDOW;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);

  localparam int CHAN_W    = 4;
  localparam int LEN_W     = 4;
  localparam int SPEED_W   = 16;
  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = 12;
  localparam int MAG_W     = SUM_W - 1;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W   = RECIP_SHIFT + 1;
  localparam int PROD_W    = MAG_W + RECIP_W;

  localparam int EN_W       = 10;
  localparam int WL_W       = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTHS = 2'd1;

  localparam logic [1:0] KIND_FILTER = 2'd0;
  localparam logic [1:0] KIND_ZERO   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HIST_AW-1:0]  base;
    logic [LEN_W-1:0]    len;
    logic [SAMPLE_W-1:0] spd;
  } cmd_t;

  // ceil(2^16 / len): exact floor division for magnitudes up to 12 * 127
  function automatic logic [RECIP_W-1:0] recip(input logic [LEN_W-1:0] len);
    logic [RECIP_W-1:0] r;
    unique case (len)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      default: r = 17'd5462;
    endcase
    return r;
  endfunction

endpackage

// ----- design/mma_front.sv -----
module mma_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mma_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              full,
  output logic                              push,
  output mma_pkg::cmd_t                     push_cmd
);

  logic [mma_pkg::EN_W-1:0]     channel_enable;
  logic [mma_pkg::WL_W-1:0]     window_lengths;
  logic [mma_pkg::CHAN_W-1:0]   chan;
  logic [mma_pkg::CHAN_W-1:0]   idx;
  logic signed [mma_pkg::SPEED_W-1:0] speed;
  logic                         chan_ok;
  logic                         enabled;
  logic [mma_pkg::EN_W-1:0]     en_sh;
  logic [mma_pkg::WL_W-1:0]     wl_sh;
  logic [mma_pkg::LEN_W-1:0]    nib;
  logic [mma_pkg::LEN_W-1:0]    len;
  logic [mma_pkg::SAMPLE_W-1:0] spd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign push      = s_tvalid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '0;
      window_lengths <= '0;
    end else if (cfg_valid) begin
      priority if (cfg_index == mma_pkg::REG_CHANNEL_ENABLE) begin
        channel_enable <= cfg_data[mma_pkg::EN_W-1:0];
      end else if (cfg_index == mma_pkg::REG_WINDOW_LENGTHS) begin
        window_lengths <= cfg_data[mma_pkg::WL_W-1:0];
      end
    end
  end

  always_comb begin
    chan    = s_tdata[mma_pkg::CHAN_W-1:0];
    speed   = $signed(s_tdata[mma_pkg::CHAN_W +: mma_pkg::SPEED_W]);
    chan_ok = (chan != '0) && (chan <= mma_pkg::CHAN_W'(mma_pkg::NUM_CHANNELS));
    idx     = chan - mma_pkg::CHAN_W'(1);
    en_sh   = channel_enable >> idx;
    enabled = chan_ok && en_sh[0];
    wl_sh   = window_lengths >> {idx, 2'b00};
    nib     = wl_sh[mma_pkg::LEN_W-1:0];

    priority if (nib == '0) begin
      len = mma_pkg::LEN_W'(1);
    end else if (nib > mma_pkg::LEN_W'(mma_pkg::MAX_WINDOW)) begin
      len = mma_pkg::LEN_W'(mma_pkg::MAX_WINDOW);
    end else begin
      len = nib;
    end

    // saturate to -127..127
    priority if (speed > 16'sd127) begin
      spd = 8'sd127;
    end else if (speed < -16'sd127) begin
      spd = -8'sd127;
    end else begin
      spd = speed[mma_pkg::SAMPLE_W-1:0];
    end

    push_cmd.base = mma_pkg::HIST_AW'(idx) * mma_pkg::HIST_AW'(mma_pkg::MAX_WINDOW);
    push_cmd.len  = len;
    push_cmd.spd  = spd;
    priority if (s_tuser) begin
      push_cmd.kind = mma_pkg::KIND_CLEAR;
    end else if (enabled) begin
      push_cmd.kind = mma_pkg::KIND_FILTER;
    end else begin
      push_cmd.kind = mma_pkg::KIND_ZERO;
    end
  end

endmodule

// ----- design/mma_cmd_fifo.sv -----
module mma_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mma_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mma_pkg::cmd_t pop_cmd,
  output logic          empty
);

  mma_pkg::cmd_t               entries [mma_pkg::CMDQ_DEPTH];
  logic [mma_pkg::CMDQ_AW-1:0] wr_ptr;
  logic [mma_pkg::CMDQ_AW-1:0] rd_ptr;
  logic [mma_pkg::CMDQ_AW:0]   count;

  assign full    = (count == (mma_pkg::CMDQ_AW+1)'(mma_pkg::CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mma_pkg::CMDQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mma_pkg::CMDQ_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (mma_pkg::CMDQ_AW+1)'(1);
        2'b01:   count <= count - (mma_pkg::CMDQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/mma_back.sv -----
module mma_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  mma_pkg::cmd_t                 cmd,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mma_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SHIFT  = 2'd1;
  localparam logic [1:0] S_WRITE0 = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]                        state;
  logic [1:0]                        state_next;
  mma_pkg::cmd_t                     cur;
  logic signed [mma_pkg::SUM_W-1:0]  sum;
  logic signed [mma_pkg::SUM_W-1:0]  sum_next;
  logic [mma_pkg::LEN_W-1:0]         ofs;
  logic [mma_pkg::LEN_W-1:0]         ofs_next;
  logic [mma_pkg::PROD_W-1:0]        prod;
  logic                              out_valid;
  logic [mma_pkg::M_TDATA_W-1:0]     out_data;

  logic [mma_pkg::SAMPLE_W-1:0]      hist [mma_pkg::HIST_DEPTH];
  logic [mma_pkg::HIST_DEPTH-1:0]    vld;
  logic [mma_pkg::SAMPLE_W-1:0]      rd_data;
  logic                              rd_vld;

  logic                              mem_re;
  logic [mma_pkg::HIST_AW-1:0]       mem_raddr;
  logic                              mem_we;
  logic [mma_pkg::HIST_AW-1:0]       mem_waddr;
  logic [mma_pkg::SAMPLE_W-1:0]      mem_wdata;
  logic                              clr;
  logic                              load_cur;
  logic                              do_mul;
  logic                              out_load;
  logic [mma_pkg::M_TDATA_W-1:0]     out_load_data;
  logic                              out_free;
  logic [mma_pkg::SAMPLE_W-1:0]      rd_eff;
  logic [mma_pkg::MAG_W-1:0]         sum_mag;
  logic signed [mma_pkg::SUM_W-1:0]  quot;
  logic signed [mma_pkg::SUM_W-1:0]  avg;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign out_free = !out_valid || m_tready;
  assign rd_eff   = rd_vld ? rd_data : '0;

  always_comb begin
    sum_mag = sum[mma_pkg::SUM_W-1] ? mma_pkg::MAG_W'(-sum) : mma_pkg::MAG_W'(sum);
    quot    = $signed(mma_pkg::SUM_W'(prod[mma_pkg::RECIP_SHIFT +: mma_pkg::MAG_W]));
    avg     = sum[mma_pkg::SUM_W-1] ? -quot : quot;
  end

  always_comb begin
    state_next    = state;
    sum_next      = sum;
    ofs_next      = ofs;
    pop           = 1'b0;
    clr           = 1'b0;
    load_cur      = 1'b0;
    do_mul        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    out_load      = 1'b0;
    out_load_data = '0;

    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          unique case (cmd.kind)
            mma_pkg::KIND_CLEAR: begin
              pop = 1'b1;
              clr = 1'b1;
            end
            mma_pkg::KIND_FILTER: begin
              pop      = 1'b1;
              load_cur = 1'b1;
              sum_next = mma_pkg::SUM_W'($signed(cmd.spd));
              if (cmd.len > mma_pkg::LEN_W'(1)) begin
                // fetch the entry that moves into the oldest slot of the window
                ofs_next   = cmd.len - mma_pkg::LEN_W'(2);
                mem_re     = 1'b1;
                mem_raddr  = cmd.base + mma_pkg::HIST_AW'(ofs_next);
                state_next = S_SHIFT;
              end else begin
                state_next = S_WRITE0;
              end
            end
            default: begin
              if (out_free) begin
                pop      = 1'b1;
                out_load = 1'b1;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // move entry ofs up by one and fetch the next one down
        mem_we    = 1'b1;
        mem_waddr = cur.base + mma_pkg::HIST_AW'(ofs) + mma_pkg::HIST_AW'(1);
        mem_wdata = rd_eff;
        sum_next  = sum + mma_pkg::SUM_W'($signed(rd_eff));
        if (ofs != '0) begin
          ofs_next  = ofs - mma_pkg::LEN_W'(1);
          mem_re    = 1'b1;
          mem_raddr = cur.base + mma_pkg::HIST_AW'(ofs_next);
        end else begin
          state_next = S_WRITE0;
        end
      end
      S_WRITE0: begin
        mem_we     = 1'b1;
        mem_waddr  = cur.base;
        mem_wdata  = cur.spd;
        do_mul     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = avg[mma_pkg::M_TDATA_W-1:0];
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
    ofs <= ofs_next;
    if (load_cur) begin
      cur <= cmd;
    end
    if (do_mul) begin
      prod <= mma_pkg::PROD_W'(sum_mag) * mma_pkg::PROD_W'(mma_pkg::recip(cur.len));
    end
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  // history store: an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= hist[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_waddr] <= 1'b1;
    end
    if (mem_re) begin
      rd_vld <= vld[mem_raddr] && !clr;
    end
  end

endmodule

// ----- design/multichannel_moving_average_unit.sv -----
// Per-channel boxcar moving average of motor speed commands.
// Input stream (s_*): s_tuser is the mode (0 sample, 1 clear all histories),
// s_tdata carries the channel number and the 16-bit speed. A sample for an
// enabled channel in 1..10 yields one 8-bit average on the output stream
// (m_*); a disabled or out-of-range channel yields average 0; a clear yields
// nothing. Configuration writes (cfg_*) set the enable mask (index 0) and the
// packed window lengths (index 1); cfg_ready is always high.
// A front stage classifies each transfer into a two-entry command queue; a back
// engine shifts the channel history one entry per cycle through the history
// RAM, then scales the sum by a reciprocal multiply.
// A filtered sample holds the engine in S_SHIFT (if L > 1), S_WRITE0 and S_OUT
// until its result is loaded (L is the window length, 1..12); a zero result or a
// clear is taken in S_IDLE. The engine takes one command at a time.
// Reset clears the control state, the queue and every history at once (per-entry
// valid bits), so items are taken in the cycle after reset falls.
// When m_tready is low the result is held in the output register; the engine
// stalls on the next result, and the queue fills before s_tready drops.
module multichannel_moving_average_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mma_pkg::S_TDATA_W-1:0]  s_tdata,   // [3:0] channel, [19:4] speed, [23:20] 0
  input  logic                           s_tuser,   // [0] mode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mma_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] average
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0] cfg_data
);

  mma_pkg::cmd_t push_cmd;
  mma_pkg::cmd_t pop_cmd;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  mma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mma_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  mma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .cmd      (pop_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- design/mma_checker.sv -----
`include "multichannel_moving_average_unit_assert.svh"

module mma_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mma_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // hold a stalled result
  `MMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `MMA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
  // an average of clamped speeds never reaches -128
  `MMA_ASSERT_IMP(a_avg_range, m_tvalid, m_tdata != 8'h80)
  // configuration writes are never back-pressured
  `MMA_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind multichannel_moving_average_unit mma_checker u_mma_checker (.*);
